### sv/hd_pkg.sv
// ----------------------------------------------------------------------------
// hd_pkg
// Shared sizes, tap offsets and types for the horizontal diffusion stencil.
// ----------------------------------------------------------------------------
package hd_pkg;

    localparam int GRID_ROWS    = 64;
    localparam int GRID_COLUMNS = 64;

    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 4;
    localparam int LAP_W    = SAMPLE_W + 3;
    localparam int FLUX_W   = LAP_W + 1;
    localparam int SUM_W    = FLUX_W + 2;
    localparam int PROD_W   = SUM_W + COEF_W;
    localparam int DIFF_W   = PROD_W + 1;

    // Result lag in beats and length of the sample chain.
    localparam int LAG       = 2 * GRID_ROWS + 2;
    localparam int CHAIN_LEN = 4 * GRID_ROWS + 2;

    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLUMNS);
    localparam int SEEN_W = $clog2(LAG + 1);

    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(LAG);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(GRID_ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(GRID_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LO    = ROW_W'(2);
    localparam logic [ROW_W-1:0]  ROW_HI    = ROW_W'(GRID_ROWS - 3);
    localparam logic [COL_W-1:0]  COL_LO    = COL_W'(2);
    localparam logic [COL_W-1:0]  COL_HI    = COL_W'(GRID_COLUMNS - 3);

    // Chain positions (before the shift) of the samples around the centre,
    // named by their stream offset from the centre point.
    localparam int TAP_C      = 2 * GRID_ROWS + 1;
    localparam int TAP_P1     = TAP_C - 1;
    localparam int TAP_M1     = TAP_C + 1;
    localparam int TAP_P2     = TAP_C - 2;
    localparam int TAP_M2     = TAP_C + 2;
    localparam int TAP_PR     = TAP_C - GRID_ROWS;
    localparam int TAP_MR     = TAP_C + GRID_ROWS;
    localparam int TAP_PR_P1  = TAP_PR - 1;
    localparam int TAP_PR_M1  = TAP_PR + 1;
    localparam int TAP_MR_P1  = TAP_MR - 1;
    localparam int TAP_MR_M1  = TAP_MR + 1;
    localparam int TAP_P2R    = TAP_C - 2 * GRID_ROWS;
    localparam int TAP_M2R    = TAP_C + 2 * GRID_ROWS;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-3:0] REG_COEF   = '0;
    localparam logic [COEF_W-1:0]     COEF_RESET = COEF_W'(7);

    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO = '0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample c;
        t_sample p1;
        t_sample m1;
        t_sample p2;
        t_sample m2;
        t_sample pr;
        t_sample mr;
        t_sample pr_p1;
        t_sample pr_m1;
        t_sample mr_p1;
        t_sample mr_m1;
        t_sample p2r;
        t_sample m2r;
    } t_window;

    typedef struct packed {
        logic interior;
        logic frame_end;
    } t_pt_ctl;

endpackage

### sv/hd_if.sv
// ----------------------------------------------------------------------------
// hd_if
// Stream channels of the diffusion stencil: grid beats in, results out.
// ----------------------------------------------------------------------------
interface hd_in_if import hd_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    kind;
    t_sample sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface hd_out_if import hd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample result;
    logic    frame_end;

    modport source (output valid, output result, output frame_end, input ready);
    modport sink   (input valid, input result, input frame_end, output ready);
endinterface

### sv/hd_cell.sv
// ----------------------------------------------------------------------------
// hd_cell
// One stage of the sample chain: takes its neighbor's sample on a shift.
// ----------------------------------------------------------------------------
module hd_cell import hd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_sample i_data,
    output t_sample o_data
);

    t_sample r_data;
    t_sample n_data;

    always_comb begin
        n_data = i_shift ? i_data : r_data;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### sv/hd_flux.sv
// ----------------------------------------------------------------------------
// hd_flux
// Five-stage elastic datapath: Laplacians, limited fluxes, flux sum,
// coefficient product, interior subtract and saturate into output register.
// ----------------------------------------------------------------------------
module hd_flux import hd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_window           i_win,
    input  t_pt_ctl           i_ctl,
    input  logic [COEF_W-1:0] i_coef,
    output logic              o_valid,
    input  logic              i_ready,
    output t_sample           o_result,
    output logic              o_frame_end
);

    typedef logic signed [LAP_W-1:0]  t_lap;
    typedef logic signed [FLUX_W-1:0] t_flux;

    function automatic t_lap f_lap(t_sample x, t_sample a, t_sample b,
                                   t_sample c, t_sample d);
        return (LAP_W'(x) <<< 2) - LAP_W'(a) - LAP_W'(b) - LAP_W'(c) - LAP_W'(d);
    endfunction

    // Drop a flux whose sign matches the nonzero sign of its local difference.
    function automatic t_flux f_limit(t_flux flux, logic pos, logic neg);
        if ((flux > 0 && pos) || (flux < 0 && neg)) begin
            return '0;
        end
        return flux;
    endfunction

    logic en1, en2, en3, en4, en5;

    // stage 1
    logic r_v1;
    t_lap r_s1_l0, r_s1_lxp, r_s1_lxm, r_s1_lyp, r_s1_lym;
    t_lap n_s1_l0, n_s1_lxp, n_s1_lxm, n_s1_lyp, n_s1_lym;
    logic [3:0] r_s1_pos, r_s1_neg, n_s1_pos, n_s1_neg;
    t_sample r_s1_c;
    t_pt_ctl r_s1_ctl;

    // stage 2
    logic  r_v2;
    t_flux r_s2_fxp, r_s2_fxm, r_s2_fyp, r_s2_fym;
    t_flux n_s2_fxp, n_s2_fxm, n_s2_fyp, n_s2_fym;
    t_sample r_s2_c;
    t_pt_ctl r_s2_ctl;

    // stage 3
    logic r_v3;
    logic signed [SUM_W-1:0] r_s3_sum, n_s3_sum;
    t_sample r_s3_c;
    t_pt_ctl r_s3_ctl;

    // stage 4
    logic r_v4;
    logic signed [PROD_W-1:0] r_s4_prod, n_s4_prod, w_sum_x, w_coef_x;
    t_sample r_s4_c;
    t_pt_ctl r_s4_ctl;

    // stage 5, output register
    logic r_v5;
    t_sample r_s5_result, n_s5_result;
    logic r_s5_frame_end;
    logic signed [DIFF_W-1:0] w_diff;

    // Each stage loads when it is empty or its contents move on.
    assign en5 = !r_v5 || i_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        n_s1_l0  = f_lap(i_win.c, i_win.m1, i_win.p1, i_win.mr, i_win.pr);
        n_s1_lxp = f_lap(i_win.p1, i_win.c, i_win.p2, i_win.mr_p1, i_win.pr_p1);
        n_s1_lxm = f_lap(i_win.m1, i_win.m2, i_win.c, i_win.mr_m1, i_win.pr_m1);
        n_s1_lyp = f_lap(i_win.pr, i_win.pr_m1, i_win.pr_p1, i_win.c, i_win.p2r);
        n_s1_lym = f_lap(i_win.mr, i_win.mr_m1, i_win.mr_p1, i_win.m2r, i_win.c);
        n_s1_pos = {i_win.c > i_win.mr, i_win.pr > i_win.c,
                    i_win.c > i_win.m1, i_win.p1 > i_win.c};
        n_s1_neg = {i_win.c < i_win.mr, i_win.pr < i_win.c,
                    i_win.c < i_win.m1, i_win.p1 < i_win.c};
    end

    always_comb begin
        n_s2_fxp = f_limit(FLUX_W'(r_s1_lxp) - FLUX_W'(r_s1_l0), r_s1_pos[0], r_s1_neg[0]);
        n_s2_fxm = f_limit(FLUX_W'(r_s1_l0) - FLUX_W'(r_s1_lxm), r_s1_pos[1], r_s1_neg[1]);
        n_s2_fyp = f_limit(FLUX_W'(r_s1_lyp) - FLUX_W'(r_s1_l0), r_s1_pos[2], r_s1_neg[2]);
        n_s2_fym = f_limit(FLUX_W'(r_s1_l0) - FLUX_W'(r_s1_lym), r_s1_pos[3], r_s1_neg[3]);
    end

    always_comb begin
        n_s3_sum = SUM_W'(r_s2_fxp) - SUM_W'(r_s2_fxm)
                 + SUM_W'(r_s2_fyp) - SUM_W'(r_s2_fym);
    end

    always_comb begin
        w_sum_x   = PROD_W'(r_s3_sum);
        w_coef_x  = PROD_W'($signed({1'b0, i_coef}));
        n_s4_prod = w_sum_x * w_coef_x;
    end

    always_comb begin
        w_diff = DIFF_W'(r_s4_c) - DIFF_W'(r_s4_prod);
        if (!r_s4_ctl.interior) begin
            n_s5_result = r_s4_c;
        end else if (w_diff > DIFF_W'($signed({1'b0, {(SAMPLE_W-1){1'b1}}}))) begin
            n_s5_result = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (w_diff < DIFF_W'($signed({1'b1, {(SAMPLE_W-1){1'b0}}}))) begin
            n_s5_result = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            n_s5_result = w_diff[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_l0  <= n_s1_l0;
            r_s1_lxp <= n_s1_lxp;
            r_s1_lxm <= n_s1_lxm;
            r_s1_lyp <= n_s1_lyp;
            r_s1_lym <= n_s1_lym;
            r_s1_pos <= n_s1_pos;
            r_s1_neg <= n_s1_neg;
            r_s1_c   <= i_win.c;
            r_s1_ctl <= i_ctl;
        end
        if (en2) begin
            r_s2_fxp <= n_s2_fxp;
            r_s2_fxm <= n_s2_fxm;
            r_s2_fyp <= n_s2_fyp;
            r_s2_fym <= n_s2_fym;
            r_s2_c   <= r_s1_c;
            r_s2_ctl <= r_s1_ctl;
        end
        if (en3) begin
            r_s3_sum <= n_s3_sum;
            r_s3_c   <= r_s2_c;
            r_s3_ctl <= r_s2_ctl;
        end
        if (en4) begin
            r_s4_prod <= n_s4_prod;
            r_s4_c    <= r_s3_c;
            r_s4_ctl  <= r_s3_ctl;
        end
        if (en5) begin
            r_s5_result    <= n_s5_result;
            r_s5_frame_end <= r_s4_ctl.frame_end;
        end
    end

    assign o_valid     = r_v5;
    assign o_result    = r_s5_result;
    assign o_frame_end = r_s5_frame_end;

endmodule

### sv/horizontal_diffusion_stencil.sv
// ----------------------------------------------------------------------------
// horizontal_diffusion_stencil
// Flux-limited horizontal diffusion over a streamed Q16.16 grid.
// ----------------------------------------------------------------------------
//   Port       Dir  Handshake            Beat contents
//   i_grid     in   valid/ready          kind, sample
//   o_diff     out  valid/ready          result, frame_end
//   APB        in   psel/penable/pready  diffusion coefficient at byte 0
//
// One beat per cycle while i_grid.ready is high; the sample chain shifts in
// the cycle a kept beat is taken. A result passes the five datapath stages
// once its window completes; a frame's first result needs 2*GRID_ROWS+3 beats.
// Stalls on o_diff fill the five datapath stages before i_grid.ready drops.
// Reset (synchronous) clears fill count, position and valids; coefficient is 7.
// ----------------------------------------------------------------------------
module horizontal_diffusion_stencil import hd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    hd_in_if.sink                  i_grid,
    hd_out_if.source               o_diff,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [SEEN_W-1:0] r_seen, n_seen;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [COEF_W-1:0] r_coef, n_coef;

    logic    w_acc, w_full, w_drop, w_shift, w_flux_ready, w_flux_valid;
    t_sample w_new;
    t_sample w_chain [CHAIN_LEN];
    t_window w_win;
    t_pt_ctl w_ctl;

    assign w_acc   = i_grid.valid && i_grid.ready;
    assign w_full  = (r_seen == SEEN_FULL);
    // A flush that arrives while the window is still filling is dropped.
    assign w_drop  = i_grid.kind && !w_full;
    assign w_shift = w_acc && !w_drop;
    assign w_new   = i_grid.kind ? SAMPLE_ZERO : i_grid.sample;

    assign i_grid.ready = w_flux_ready;
    assign w_flux_valid = i_grid.valid && w_full;

    for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
        if (k == 0) begin : g_head
            hd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_data  (w_new),
                .o_data  (w_chain[k])
            );
        end else begin : g_body
            hd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_data  (w_chain[k-1]),
                .o_data  (w_chain[k])
            );
        end
    end

    always_comb begin
        w_win.c     = w_chain[TAP_C];
        w_win.p1    = w_chain[TAP_P1];
        w_win.m1    = w_chain[TAP_M1];
        w_win.p2    = w_chain[TAP_P2];
        w_win.m2    = w_chain[TAP_M2];
        w_win.pr    = w_chain[TAP_PR];
        w_win.mr    = w_chain[TAP_MR];
        w_win.pr_p1 = w_chain[TAP_PR_P1];
        w_win.pr_m1 = w_chain[TAP_PR_M1];
        w_win.mr_p1 = w_chain[TAP_MR_P1];
        w_win.mr_m1 = w_chain[TAP_MR_M1];
        w_win.p2r   = w_chain[TAP_P2R];
        w_win.m2r   = w_chain[TAP_M2R];

        w_ctl.interior  = (r_row inside {[ROW_LO:ROW_HI]}) &&
                          (r_col inside {[COL_LO:COL_HI]});
        w_ctl.frame_end = (r_row == ROW_LAST) && (r_col == COL_LAST);
    end

    always_comb begin
        n_seen = r_seen;
        n_row  = r_row;
        n_col  = r_col;
        if (w_shift && !w_full) begin
            n_seen = r_seen + SEEN_W'(1);
        end
        if (w_acc && w_full) begin
            if (r_row == ROW_LAST) begin
                n_row = '0;
                n_col = (r_col == COL_LAST) ? '0 : r_col + COL_W'(1);
            end else begin
                n_row = r_row + ROW_W'(1);
            end
            // A flush that closes the frame restarts the fill.
            if (w_ctl.frame_end && i_grid.kind) begin
                n_seen = '0;
            end
        end
    end

    always_comb begin
        n_coef = r_coef;
        if (psel && penable && pwrite && pready &&
            paddr[CFG_ADDR_W-1:2] == REG_COEF) begin
            n_coef = pwdata[COEF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_coef <= COEF_RESET;
        end else begin
            r_seen <= n_seen;
            r_row  <= n_row;
            r_col  <= n_col;
            r_coef <= n_coef;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_COEF) ?
                    APB_DATA_W'(r_coef) : '0;

    hd_flux u_flux (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_flux_valid),
        .o_ready     (w_flux_ready),
        .i_win       (w_win),
        .i_ctl       (w_ctl),
        .i_coef      (r_coef),
        .o_valid     (o_diff.valid),
        .i_ready     (o_diff.ready),
        .o_result    (o_diff.result),
        .o_frame_end (o_diff.frame_end)
    );

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_FULL)
        else $error("fill count beyond lag");

    a_pos_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen != SEEN_FULL) |-> (r_row == '0 && r_col == '0))
        else $error("output position moved while window filling");

    a_drop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_drop) |=> ($stable(r_seen) && $stable(r_row) && $stable(r_col)))
        else $error("dropped flush changed state");

endmodule
